// ===== design/g4fb_pkg.sv =====
`default_nettype none

package g4fb_pkg;

   localparam int unsigned DEFAULT_MAX_WIDTH  = 1024;
   localparam int unsigned DEFAULT_MAX_HEIGHT = 1024;

   localparam int unsigned DIM_BITS  = 11;
   localparam int unsigned POS_BITS  = 10;
   localparam int unsigned GRAY_BITS = 8;
   localparam int unsigned NIB_BITS  = 4;
   localparam int unsigned REQ_BITS  = 2;

   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 11'd600;
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 11'd800;

   localparam int unsigned CSR_INDEX_BITS = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH  = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT = 8'd1;

   localparam logic [REQ_BITS-1:0] REQ_WRITE = 2'd0;
   localparam logic [REQ_BITS-1:0] REQ_READ  = 2'd1;
   localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd2;

   localparam logic [GRAY_BITS-1:0] GRAY_BLANK = 8'hFF;
   localparam logic [NIB_BITS-1:0]  NIB_FULL   = 4'hF;

   localparam int unsigned QUEUE_DEPTH = 2;

   // x / 17 as (x * 241) >> 12, exact for 8-bit x
   localparam logic [15:0] RECIP_17    = 16'd241;
   localparam int unsigned RECIP_SHIFT = 12;

   typedef struct packed {
      logic [REQ_BITS-1:0]  req_type;
      logic [POS_BITS-1:0]  pos_x;
      logic [POS_BITS-1:0]  pos_y;
      logic [GRAY_BITS-1:0] gray_value;
   } req_payload_type;

   typedef struct packed {
      logic [GRAY_BITS-1:0] read_gray;
      logic                 in_bounds;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                odd;
      logic [NIB_BITS-1:0] nib;
   } cmd_type;

   function automatic logic [NIB_BITS-1:0] level_of_gray(input logic [GRAY_BITS-1:0] gray);
      logic [GRAY_BITS-1:0] inv;
      logic [15:0] prod;
      inv  = ~gray;
      prod = 16'(inv) * RECIP_17;
      return prod[RECIP_SHIFT +: NIB_BITS];
   endfunction

   function automatic logic [GRAY_BITS-1:0] gray_of_level(input logic [NIB_BITS-1:0] nib);
      return ~{nib, nib};
   endfunction

endpackage

`default_nettype wire

// ===== design/g4fb_front.sv =====
`default_nettype none

module g4fb_front #(
   parameter int unsigned MAX_WIDTH  = g4fb_pkg::DEFAULT_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = g4fb_pkg::DEFAULT_MAX_HEIGHT,
   parameter int unsigned ADDR_BITS  = 19
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_valid,
   output logic                                     req_stall,
   input  wire  g4fb_pkg::req_payload_type          req_data,
   input  wire                                      csr_write,
   input  wire  [g4fb_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  wire  [g4fb_pkg::DIM_BITS-1:0]            csr_wdata,
   input  wire                                      queue_full,
   input  wire                                      init_busy,
   output logic                                     push,
   output g4fb_pkg::cmd_type                        push_cmd,
   output logic [ADDR_BITS:0]                       push_addr
);

   localparam int unsigned WB = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HB = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned SB = $clog2((MAX_WIDTH + 1) / 2 + 1);
   localparam int unsigned MB = (HB > g4fb_pkg::POS_BITS) ? HB : g4fb_pkg::POS_BITS;
   localparam int unsigned PB = MB + SB;

   logic [g4fb_pkg::DIM_BITS-1:0] width_ff, width_in;
   logic [g4fb_pkg::DIM_BITS-1:0] height_ff, height_in;

   logic [WB-1:0] eff_w;
   logic [HB-1:0] eff_h;
   logic [WB:0]   stride_sum;
   logic [SB-1:0] stride;
   logic          is_clear;
   logic          in_frame;
   logic [MB-1:0] mul_a;
   logic [PB-1:0] prod;
   logic [PB:0]   byte_sum;
   logic [g4fb_pkg::POS_BITS-1:0] col;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            g4fb_pkg::CSR_WIDTH:  width_in  = csr_wdata;
            g4fb_pkg::CSR_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= g4fb_pkg::WIDTH_RESET;
         height_ff <= g4fb_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // saturate geometry to the store
   assign eff_w = (32'(width_ff) > 32'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : WB'(width_ff);
   assign eff_h = (32'(height_ff) > 32'(MAX_HEIGHT)) ? HB'(MAX_HEIGHT) : HB'(height_ff);
   assign stride_sum = (WB + 1)'(eff_w) + (WB + 1)'(1);
   assign stride     = SB'(stride_sum >> 1);

   assign is_clear = (req_data.req_type == g4fb_pkg::REQ_CLEAR);
   assign in_frame = (32'(req_data.pos_x) < 32'(eff_w)) && (32'(req_data.pos_y) < 32'(eff_h));

   // row offset for a pixel, byte count for a clear
   assign mul_a    = is_clear ? MB'(eff_h) : MB'(req_data.pos_y);
   assign prod     = PB'(mul_a) * PB'(stride);
   assign col      = is_clear ? '0 : (req_data.pos_x >> 1);
   assign byte_sum = (PB + 1)'(prod) + (PB + 1)'(col);

   always_comb begin
      push_cmd.odd = req_data.pos_x[0];
      push_cmd.nib = g4fb_pkg::level_of_gray(req_data.gray_value);
      unique case (req_data.req_type)
         g4fb_pkg::REQ_WRITE: push_cmd.op = in_frame ? g4fb_pkg::OP_WRITE : g4fb_pkg::OP_NONE;
         g4fb_pkg::REQ_READ:  push_cmd.op = in_frame ? g4fb_pkg::OP_READ : g4fb_pkg::OP_NONE;
         g4fb_pkg::REQ_CLEAR: begin
            push_cmd.op  = g4fb_pkg::OP_CLEAR;
            push_cmd.nib = req_data.gray_value[g4fb_pkg::GRAY_BITS-1 -: g4fb_pkg::NIB_BITS];
         end
         default:             push_cmd.op = g4fb_pkg::OP_NONE;
      endcase
   end

   assign push_addr = (ADDR_BITS + 1)'(byte_sum);
   assign req_stall = queue_full || init_busy;
   assign push      = req_valid && !req_stall;

endmodule

`default_nettype wire

// ===== design/g4fb_queue.sv =====
`default_nettype none

module g4fb_queue #(
   parameter int unsigned DATA_BITS = 8
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  wire  [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  wire                  pop,
   output logic                 nonempty,
   output logic [DATA_BITS-1:0] pop_data
);

   localparam int unsigned Depth = g4fb_pkg::QUEUE_DEPTH;
   localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntBits = $clog2(Depth + 1);

   logic [DATA_BITS-1:0] entry_ff [Depth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]   count_ff, count_in;

   assign full     = (count_ff == CntBits'(Depth));
   assign nonempty = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(Depth - 1)) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(Depth - 1)) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntBits'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/g4fb_back.sv =====
`default_nettype none

module g4fb_back #(
   parameter int unsigned STORE_BYTES = 524288,
   parameter int unsigned ADDR_BITS   = 19
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              queue_valid,
   input  wire  g4fb_pkg::cmd_type          queue_cmd,
   input  wire  [ADDR_BITS:0]               queue_addr,
   output logic                             pop,
   output logic                             init_busy,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output g4fb_pkg::rsp_payload_type        rsp_data
);

   typedef enum logic [2:0] {
      ST_INIT  = 3'b001,
      ST_RUN   = 3'b010,
      ST_CLEAR = 3'b100
   } state_type;

   logic [g4fb_pkg::NIB_BITS-1:0] hi_mem [STORE_BYTES];
   logic [g4fb_pkg::NIB_BITS-1:0] lo_mem [STORE_BYTES];

   state_type                     state_ff, state_in;
   logic [ADDR_BITS:0]            count_ff, count_in;
   logic [ADDR_BITS:0]            limit_ff, limit_in;
   logic [g4fb_pkg::NIB_BITS-1:0] fill_ff, fill_in;

   logic                          sweep;
   logic                          wr_hi, wr_lo, rd_en;
   logic [ADDR_BITS-1:0]          wr_addr;
   logic [g4fb_pkg::NIB_BITS-1:0] wr_nib;
   logic [g4fb_pkg::NIB_BITS-1:0] rd_hi_ff, rd_lo_ff;
   logic [g4fb_pkg::NIB_BITS-1:0] rd_nib;

   logic                          s1_valid_ff;
   g4fb_pkg::op_type              s1_op_ff;
   logic                          s1_odd_ff;
   logic                          s1_adv;
   logic                          out_valid_ff;
   g4fb_pkg::rsp_payload_type     out_data_ff;
   g4fb_pkg::rsp_payload_type     out_data_in;

   assign sweep     = (state_ff != ST_RUN);
   assign init_busy = (state_ff == ST_INIT);
   assign s1_adv    = !out_valid_ff || !rsp_stall;
   assign pop       = (state_ff == ST_RUN) && queue_valid && (!s1_valid_ff || s1_adv);

   assign rd_en   = pop && (queue_cmd.op == g4fb_pkg::OP_READ);
   assign wr_hi   = sweep || (pop && (queue_cmd.op == g4fb_pkg::OP_WRITE) && !queue_cmd.odd);
   assign wr_lo   = sweep || (pop && (queue_cmd.op == g4fb_pkg::OP_WRITE) && queue_cmd.odd);
   assign wr_addr = sweep ? count_ff[ADDR_BITS-1:0] : queue_addr[ADDR_BITS-1:0];
   assign wr_nib  = sweep ? fill_ff : queue_cmd.nib;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      limit_in = limit_ff;
      fill_in  = fill_ff;
      unique case (state_ff) inside
         ST_INIT, ST_CLEAR: begin
            count_in = count_ff + (ADDR_BITS + 1)'(1);
            if (count_in == limit_ff) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (pop && (queue_cmd.op == g4fb_pkg::OP_CLEAR) && (queue_addr != '0)) begin
               state_in = ST_CLEAR;
               count_in = '0;
               limit_in = queue_addr;
               fill_in  = queue_cmd.nib;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         count_ff <= '0;
         limit_ff <= (ADDR_BITS + 1)'(STORE_BYTES);
         fill_ff  <= g4fb_pkg::NIB_FULL;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         limit_ff <= limit_in;
         fill_ff  <= fill_in;
      end
   end

   // pixel store, high nibble holds the even column
   always_ff @(posedge clock) begin
      if (wr_hi) begin
         hi_mem[wr_addr] <= wr_nib;
      end
      if (rd_en) begin
         rd_hi_ff <= hi_mem[queue_addr[ADDR_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_lo) begin
         lo_mem[wr_addr] <= wr_nib;
      end
      if (rd_en) begin
         rd_lo_ff <= lo_mem[queue_addr[ADDR_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= pop || (s1_valid_ff && !s1_adv);
         out_valid_ff <= (s1_valid_ff && s1_adv) || (out_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_op_ff  <= queue_cmd.op;
         s1_odd_ff <= queue_cmd.odd;
      end
      if (s1_valid_ff && s1_adv) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rd_nib = s1_odd_ff ? rd_lo_ff : rd_hi_ff;

   always_comb begin
      out_data_in.in_bounds = (s1_op_ff != g4fb_pkg::OP_NONE);
      out_data_in.read_gray = (s1_op_ff == g4fb_pkg::OP_READ) ?
                              g4fb_pkg::gray_of_level(rd_nib) : g4fb_pkg::GRAY_BLANK;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN) |-> (count_ff < limit_ff))
      else $error("sweep counter past its limit");

   a_held_read: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_op_ff) && $stable(rd_hi_ff)
                                    && $stable(rd_lo_ff)))
      else $error("waiting read lost its data");

   a_clear_ends_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> (state_ff == ST_CLEAR || state_ff == ST_RUN))
      else $error("clear sweep left to a bad state");

   a_no_access_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep |-> (!rd_en && !pop))
      else $error("store accessed during a sweep");

endmodule

`default_nettype wire

// ===== design/gray4_packed_framebuffer_unit.sv =====
`default_nettype none

// 4-bit grayscale framebuffer, two pixels per byte, with the even column in the high
// nibble and a row stride of (width + 1) / 2 bytes. Pixel writes and reads are taken one
// per cycle while req_stall is low; a read is answered through a two-entry request queue,
// a registered store read and a registered response. A clear request sweeps stride * height
// bytes, one byte per cycle, and later requests wait in the queue until the sweep is done.
// After reset the store is filled with 0xFF by a sweep over ((MAX_WIDTH + 1) / 2) *
// MAX_HEIGHT bytes (524288 with the default sizes), during which req_stall stays high;
// configuration writes are taken at any time.
module gray4_packed_framebuffer_unit #(
   parameter int unsigned MAX_WIDTH  = g4fb_pkg::DEFAULT_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = g4fb_pkg::DEFAULT_MAX_HEIGHT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  g4fb_pkg::req_payload_type     req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output g4fb_pkg::rsp_payload_type           rsp_data,
   input  wire                                 csr_write,
   input  wire  [g4fb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire  [g4fb_pkg::DIM_BITS-1:0]       csr_wdata
);

   localparam int unsigned StoreBytes = ((MAX_WIDTH + 1) / 2) * MAX_HEIGHT;
   localparam int unsigned AddrBits   = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
   localparam int unsigned EntryBits  = $bits(g4fb_pkg::cmd_type) + AddrBits + 1;

   logic                  push, pop;
   logic                  queue_full, queue_valid;
   logic                  init_busy;
   g4fb_pkg::cmd_type     push_cmd, pop_cmd;
   logic [AddrBits:0]     push_addr, pop_addr;
   logic [EntryBits-1:0]  pop_entry;

   g4fb_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .ADDR_BITS  (AddrBits)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .init_busy  (init_busy),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_addr  (push_addr)
   );

   g4fb_queue #(
      .DATA_BITS (EntryBits)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_cmd, push_addr}),
      .full      (queue_full),
      .pop       (pop),
      .nonempty  (queue_valid),
      .pop_data  (pop_entry)
   );

   assign pop_cmd  = g4fb_pkg::cmd_type'(pop_entry[EntryBits-1 -: $bits(g4fb_pkg::cmd_type)]);
   assign pop_addr = pop_entry[AddrBits:0];

   g4fb_back #(
      .STORE_BYTES (StoreBytes),
      .ADDR_BITS   (AddrBits)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (queue_valid),
      .queue_cmd   (pop_cmd),
      .queue_addr  (pop_addr),
      .pop         (pop),
      .init_busy   (init_busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// ===== tb/tb_gray4_packed_framebuffer_unit.sv =====
`default_nettype none

module tb_gray4_packed_framebuffer_unit;
   import g4fb_pkg::*;

   localparam int unsigned STORE_BYTES =
      ((DEFAULT_MAX_WIDTH + 1) / 2) * DEFAULT_MAX_HEIGHT;
   localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;

   class pixel_mirror;
      bit [GRAY_BITS-1:0] mirror_bytes [STORE_BYTES];
      logic [DIM_BITS-1:0] width_reg;
      logic [DIM_BITS-1:0] height_reg;
      rsp_payload_type answers_due [$];
      int mismatches;

      function new();
         foreach (mirror_bytes[i]) mirror_bytes[i] = 8'hFF;
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         mismatches = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [DIM_BITS-1:0] value);
         case (index)
            CSR_WIDTH: width_reg = value;
            CSR_HEIGHT: height_reg = value;
            default: ;
         endcase
      endfunction

      function int unsigned active_width();
         return (width_reg > DEFAULT_MAX_WIDTH) ? DEFAULT_MAX_WIDTH : width_reg;
      endfunction

      function int unsigned active_height();
         return (height_reg > DEFAULT_MAX_HEIGHT) ? DEFAULT_MAX_HEIGHT : height_reg;
      endfunction

      function int pending();
         return answers_due.size();
      endfunction

      function void apply_request(req_payload_type r);
         int unsigned w;
         int unsigned h;
         int unsigned stride;
         int unsigned idx;
         int unsigned lvl;
         rsp_payload_type e;
         w = active_width();
         h = active_height();
         stride = (w + 1) / 2;
         e.read_gray = GRAY_BLANK;
         e.in_bounds = 1'b0;
         case (r.req_type)
            REQ_CLEAR: begin
               for (int unsigned i = 0; i < stride * h; i++)
                  mirror_bytes[i] = {r.gray_value[7:4], r.gray_value[7:4]};
               e.in_bounds = 1'b1;
            end
            REQ_WRITE, REQ_READ: begin
               if (r.pos_x < w && r.pos_y < h) begin
                  idx = r.pos_y * stride + r.pos_x / 2;
                  e.in_bounds = 1'b1;
                  if (r.req_type == REQ_WRITE) begin
                     lvl = (255 - r.gray_value) / 17;
                     if (r.pos_x[0])
                        mirror_bytes[idx][3:0] = 4'(lvl);
                     else
                        mirror_bytes[idx][7:4] = 4'(lvl);
                  end else begin
                     lvl = r.pos_x[0] ? mirror_bytes[idx][3:0] : mirror_bytes[idx][7:4];
                     e.read_gray = 8'(255 - lvl * 17);
                  end
               end
            end
            default: ;
         endcase
         answers_due.push_back(e);
      endfunction

      function void compare_response(rsp_payload_type a);
         rsp_payload_type e;
         if (answers_due.size() == 0) begin
            $error("response with no request outstanding: read_gray %0d in_bounds %0d",
                   a.read_gray, a.in_bounds);
            mismatches++;
            return;
         end
         e = answers_due.pop_front();
         if (a.read_gray !== e.read_gray) begin
            $error("read_gray expected %0d actual %0d", e.read_gray, a.read_gray);
            mismatches++;
         end
         if (a.in_bounds !== e.in_bounds) begin
            $error("in_bounds expected %0d actual %0d", e.in_bounds, a.in_bounds);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [DIM_BITS-1:0] csr_wdata = '0;

   pixel_mirror fb;
   bit idle_on = 1'b1;
   int rsp_run = 0;

   gray4_packed_framebuffer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side back-pressure in bursts
   always @(posedge clock) begin
      if (rsp_run > 0) begin
         rsp_run--;
      end else if (idle_on && !reset && !rsp_stall && $urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         rsp_run = $urandom_range(0, 7);
      end else begin
         rsp_stall <= 1'b0;
         rsp_run = $urandom_range(0, 15);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         fb.compare_response(rsp_data);
   end

   task automatic send_request(input logic [REQ_BITS-1:0] kind, input int unsigned x,
                               input int unsigned y, input int unsigned gray);
      req_payload_type r;
      r.req_type = kind;
      r.pos_x = POS_BITS'(x);
      r.pos_y = POS_BITS'(y);
      r.gray_value = GRAY_BITS'(gray);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      fb.apply_request(r);
   endtask

   // hold off until every answer is back and the block has gone quiet
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (fb.pending() != 0);
      repeat (4) @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned h);
      logic [CSR_INDEX_BITS-1:0] junk_index;
      logic [DIM_BITS-1:0] junk_data;
      junk_index = CSR_INDEX_BITS'($urandom_range(2, 255));
      junk_data = DIM_BITS'($urandom);
      csr_write <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= DIM_BITS'(w);
      @(posedge clock);
      fb.write_register(CSR_WIDTH, DIM_BITS'(w));
      csr_index <= CSR_HEIGHT;
      csr_wdata <= DIM_BITS'(h);
      @(posedge clock);
      fb.write_register(CSR_HEIGHT, DIM_BITS'(h));
      csr_index <= junk_index;
      csr_wdata <= junk_data;
      @(posedge clock);
      fb.write_register(junk_index, junk_data);
      csr_write <= 1'b0;
   endtask

   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned we;
      int unsigned he;
      int unsigned x;
      int unsigned y;
      int unsigned roll;
      logic [REQ_BITS-1:0] kind;

      fb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset geometry
      send_request(REQ_READ, 0, 0, 0);
      send_request(REQ_WRITE, 599, 799, 0);
      send_request(REQ_READ, 599, 799, 0);
      send_request(REQ_WRITE, 1, 0, 128);
      send_request(REQ_READ, 1, 0, 0);
      send_request(REQ_READ, 600, 0, 0);
      send_request(REQ_WRITE, 0, 800, 255);
      send_request(REQ_UNUSED, 1023, 1023, 255);
      drain();

      // oversized registers saturate, single full sweep
      set_geometry(2047, 2047);
      send_request(REQ_CLEAR, 0, 0, 8'hA5);
      send_request(REQ_READ, 1023, 1023, 0);
      send_request(REQ_WRITE, 1022, 1023, 17);
      send_request(REQ_READ, 1022, 1023, 0);
      send_request(REQ_READ, 599, 799, 0);
      drain();

      // zero width
      set_geometry(0, 1024);
      send_request(REQ_CLEAR, 0, 0, 0);
      send_request(REQ_WRITE, 0, 0, 0);
      drain();

      set_geometry(1, 1);
      send_request(REQ_WRITE, 0, 0, 0);
      send_request(REQ_READ, 0, 0, 0);
      send_request(REQ_CLEAR, 0, 0, 8'hF0);
      send_request(REQ_READ, 0, 0, 0);
      send_request(REQ_READ, 1, 0, 0);
      drain();

      // odd width
      set_geometry(3, 2);
      send_request(REQ_CLEAR, 0, 0, 8'h3C);
      send_request(REQ_READ, 2, 1, 0);
      send_request(REQ_WRITE, 2, 1, 255);
      send_request(REQ_READ, 2, 1, 0);
      send_request(REQ_READ, 3, 1, 0);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         idle_on = (phase < 8);
         case ($urandom_range(0, 5))
            0: begin
               w = $urandom_range(1, 2047);
               h = $urandom_range(1, 16);
            end
            1: begin
               w = $urandom_range(1, 8);
               h = $urandom_range(1, 2047);
            end
            2: begin
               w = $urandom_range(0, 3);
               h = $urandom_range(0, 3);
            end
            default: begin
               w = $urandom_range(1, 48);
               h = $urandom_range(1, 48);
            end
         endcase
         set_geometry(w, h);
         we = fb.active_width();
         he = fb.active_height();
         for (int i = 0; i < 110; i++) begin
            roll = $urandom_range(0, 99);
            kind = (roll < 4) ? REQ_CLEAR : (roll < 7) ? REQ_UNUSED :
                   (roll < 52) ? REQ_WRITE : REQ_READ;
            roll = $urandom_range(0, 99);
            if (roll < 75 && we > 0 && he > 0) begin
               x = $urandom_range(0, we - 1);
               y = $urandom_range(0, he - 1);
            end else if (roll < 85) begin
               // just past the right edge (the last column at full width)
               x = (we > 1023) ? 1023 : we;
               y = $urandom_range(0, (he > 1023) ? 1023 : he);
            end else begin
               x = $urandom_range(0, 1023);
               y = $urandom_range(0, 1023);
            end
            send_request(kind, x, y, $urandom_range(0, 255));
            if ($urandom_range(0, 99) == 0)
               drain();
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (fb.mismatches == 0 && fb.pending() == 0)
         $display("gray4_packed_framebuffer_unit: match");
      else
         $display("gray4_packed_framebuffer_unit: mismatch");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("gray4_packed_framebuffer_unit: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
